@@ hw/rtl/mstp_pkg.sv @@
// Shared types, codes and constants of the timer slot pool.
package mstp_pkg;

    // Defaults of the top-level parameters
    localparam int SLOTS_DEF     = 8;
    localparam int TIME_BITS_DEF = 48;

    // Fixed field widths
    localparam int TYPE_W    = 3;
    localparam int HANDLE_W  = 4;
    localparam int PERIOD_W  = 32;
    localparam int NOW_W     = 48;
    localparam int KIND_W    = 2;
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 8;

    // Request codes
    typedef enum logic [TYPE_W-1:0] {
        REQ_CREATE = 3'd0,
        REQ_START  = 3'd1,
        REQ_STOP   = 3'd2,
        REQ_DELETE = 3'd3,
        REQ_RESET  = 3'd4,
        REQ_POLL   = 3'd5
    } req_type_t;

    // Result codes
    typedef enum logic [KIND_W-1:0] {
        KIND_OK   = 2'd0,
        KIND_ERR  = 2'd1,
        KIND_EXP  = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_ARM,
        ST_POLL_RD,
        ST_POLL_EVAL,
        ST_RESP
    } state_t;

    // Access strobes from the sequencer to the slot store
    typedef struct packed {
        logic rd_en;
        logic dl_we;
        logic pr_we;
        logic set_active;
        logic clr_active;
        logic set_armed;
        logic clr_armed;
    } slot_ctl_t;

endpackage

@@ hw/rtl/mstp_slot_store.sv @@
// Slot store: deadline and period memories plus per-slot active and armed flags.
module mstp_slot_store #(
    parameter int SLOTS     = mstp_pkg::SLOTS_DEF,
    parameter int TIME_BITS = mstp_pkg::TIME_BITS_DEF,
    localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mstp_pkg::slot_ctl_t           ctl,
    input  logic [IDX_W-1:0]              addr,
    input  logic [TIME_BITS-1:0]          wr_deadline,
    input  logic [mstp_pkg::PERIOD_W-1:0] wr_period,
    input  logic                          wr_periodic,
    output logic [TIME_BITS-1:0]          rd_deadline,
    output logic [mstp_pkg::PERIOD_W-1:0] rd_period,
    output logic                          rd_periodic,
    output logic [SLOTS-1:0]              active,
    output logic [SLOTS-1:0]              armed
);

    localparam int PR_W = mstp_pkg::PERIOD_W + 1;

    logic [TIME_BITS-1:0] dl_mem [SLOTS];
    logic [PR_W-1:0]      pr_mem [SLOTS];
    logic [TIME_BITS-1:0] rd_deadline_reg;
    logic [PR_W-1:0]      rd_pr_reg;
    logic [SLOTS-1:0]     active_reg;
    logic [SLOTS-1:0]     armed_reg;

    // Deadline memory, registered read
    always_ff @(posedge clk)
    begin
        if (ctl.dl_we)
        begin
            dl_mem[addr] <= wr_deadline;
        end
        if (ctl.rd_en)
        begin
            rd_deadline_reg <= dl_mem[addr];
        end
    end

    // Period and reload memory, registered read
    always_ff @(posedge clk)
    begin
        if (ctl.pr_we)
        begin
            pr_mem[addr] <= {wr_periodic, wr_period};
        end
        if (ctl.rd_en)
        begin
            rd_pr_reg <= pr_mem[addr];
        end
    end

    // Slot flags; memory contents only count while these are set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            armed_reg  <= '0;
        end
        else
        begin
            if (ctl.set_active)
            begin
                active_reg[addr] <= 1'b1;
            end
            else if (ctl.clr_active)
            begin
                active_reg[addr] <= 1'b0;
            end
            if (ctl.set_armed)
            begin
                armed_reg[addr] <= 1'b1;
            end
            else if (ctl.clr_armed)
            begin
                armed_reg[addr] <= 1'b0;
            end
        end
    end

    assign rd_deadline = rd_deadline_reg;
    assign rd_period   = rd_pr_reg[mstp_pkg::PERIOD_W-1:0];
    assign rd_periodic = rd_pr_reg[PR_W-1];
    assign active      = active_reg;
    assign armed       = armed_reg;

endmodule

@@ hw/rtl/mstp_seq.sv @@
// Request sequencer: decodes a request, walks the slots and drives the result register.
module mstp_seq #(
    parameter int SLOTS     = mstp_pkg::SLOTS_DEF,
    parameter int TIME_BITS = mstp_pkg::TIME_BITS_DEF,
    localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [mstp_pkg::TYPE_W-1:0]     in_type,
    input  logic [mstp_pkg::HANDLE_W-1:0]   in_handle,
    input  logic [mstp_pkg::PERIOD_W-1:0]   in_period,
    input  logic                            in_reload,
    input  logic [TIME_BITS-1:0]            in_now,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [mstp_pkg::KIND_W-1:0]     out_kind,
    output logic [mstp_pkg::HANDLE_W-1:0]   out_handle,
    output logic                            out_last,
    output mstp_pkg::slot_ctl_t             ctl,
    output logic [IDX_W-1:0]                slot_addr,
    output logic [TIME_BITS-1:0]            wr_deadline,
    output logic [mstp_pkg::PERIOD_W-1:0]   wr_period,
    output logic                            wr_periodic,
    input  logic [TIME_BITS-1:0]            rd_deadline,
    input  logic [mstp_pkg::PERIOD_W-1:0]   rd_period,
    input  logic                            rd_periodic,
    input  logic [SLOTS-1:0]                active,
    input  logic [SLOTS-1:0]                armed
);

    // Control registers
    mstp_pkg::state_t state_reg, state_next;
    logic             pool_en_reg;
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic             found_reg, found_next;
    logic             out_valid_reg, out_valid_next;

    // Payload registers
    mstp_pkg::req_type_t            req_type_reg;
    logic [mstp_pkg::HANDLE_W-1:0]  req_handle_reg;
    logic [mstp_pkg::PERIOD_W-1:0]  req_period_reg;
    logic                           req_reload_reg;
    logic [TIME_BITS-1:0]           req_now_reg;
    mstp_pkg::kind_t                resp_kind_reg, resp_kind_next;
    logic [mstp_pkg::HANDLE_W-1:0]  resp_handle_reg, resp_handle_next;
    mstp_pkg::kind_t                out_kind_reg, out_kind_next;
    logic [mstp_pkg::HANDLE_W-1:0]  out_handle_reg, out_handle_next;
    logic                           out_last_reg, out_last_next;
    logic                           push;

    // Shared decode terms
    logic                           out_free;
    logic                           slot_ok;
    logic [IDX_W-1:0]               slot_of;
    logic                           cur_active;
    logic                           cur_armed;
    logic                           scan_end;
    logic [IDX_W-1:0]               idx_inc;
    logic [mstp_pkg::HANDLE_W-1:0]  idx_handle;
    logic [TIME_BITS:0]             sum_full;
    logic [TIME_BITS-1:0]           sat_deadline;
    logic                           expired;
    logic                           eval_go;

    assign out_free   = !out_valid_reg || out_ready;
    assign slot_ok    = (req_handle_reg != '0) && (32'(req_handle_reg) <= 32'(SLOTS));
    assign slot_of    = IDX_W'(32'(req_handle_reg) - 32'd1);
    assign slot_addr  = (state_reg == mstp_pkg::ST_DECODE || state_reg == mstp_pkg::ST_ARM)
                        ? slot_of : scan_idx_reg;
    assign cur_active = active[slot_addr];
    assign cur_armed  = armed[slot_addr];
    assign scan_end   = (scan_idx_reg == IDX_W'(SLOTS - 1));
    assign idx_inc    = scan_idx_reg + IDX_W'(1);
    assign idx_handle = mstp_pkg::HANDLE_W'(32'(scan_idx_reg) + 32'd1);

    // Deadline from now plus the stored period, saturated at the top of the time range
    assign sum_full     = {1'b0, req_now_reg} + (TIME_BITS + 1)'(rd_period);
    assign sat_deadline = sum_full[TIME_BITS] ? '1 : sum_full[TIME_BITS-1:0];
    assign expired      = (req_now_reg >= rd_deadline);

    // Hold the poll walk while a held expiry cannot move to the result register
    assign eval_go = !(expired && found_reg && !out_free);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mstp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = mstp_pkg::ST_DECODE;
                end
            end
            mstp_pkg::ST_DECODE:
            begin
                case (req_type_reg)
                    mstp_pkg::REQ_CREATE:
                    begin
                        if (pool_en_reg && (req_period_reg != '0))
                        begin
                            state_next = mstp_pkg::ST_SCAN;
                        end
                        else
                        begin
                            state_next = mstp_pkg::ST_RESP;
                        end
                    end
                    mstp_pkg::REQ_START, mstp_pkg::REQ_RESET:
                    begin
                        if (slot_ok && cur_active)
                        begin
                            state_next = mstp_pkg::ST_ARM;
                        end
                        else
                        begin
                            state_next = mstp_pkg::ST_RESP;
                        end
                    end
                    mstp_pkg::REQ_POLL:
                    begin
                        if (pool_en_reg)
                        begin
                            state_next = mstp_pkg::ST_POLL_RD;
                        end
                        else
                        begin
                            state_next = mstp_pkg::ST_RESP;
                        end
                    end
                    default:
                    begin
                        state_next = mstp_pkg::ST_RESP;
                    end
                endcase
            end
            mstp_pkg::ST_SCAN:
            begin
                if (!cur_active || scan_end)
                begin
                    state_next = mstp_pkg::ST_RESP;
                end
            end
            mstp_pkg::ST_ARM:
            begin
                state_next = mstp_pkg::ST_RESP;
            end
            mstp_pkg::ST_POLL_RD:
            begin
                if (cur_active && cur_armed)
                begin
                    state_next = mstp_pkg::ST_POLL_EVAL;
                end
                else if (scan_end)
                begin
                    state_next = mstp_pkg::ST_RESP;
                end
            end
            mstp_pkg::ST_POLL_EVAL:
            begin
                if (eval_go)
                begin
                    state_next = scan_end ? mstp_pkg::ST_RESP : mstp_pkg::ST_POLL_RD;
                end
            end
            mstp_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = mstp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mstp_pkg::ST_IDLE;
            end
        endcase
    end

    // Store accesses, held result and result register loads
    always_comb
    begin
        ctl              = '0;
        scan_idx_next    = scan_idx_reg;
        found_next       = found_reg;
        resp_kind_next   = resp_kind_reg;
        resp_handle_next = resp_handle_reg;
        push             = 1'b0;
        out_kind_next    = out_kind_reg;
        out_handle_next  = out_handle_reg;
        out_last_next    = out_last_reg;
        case (state_reg)
            mstp_pkg::ST_IDLE:
            begin
            end
            mstp_pkg::ST_DECODE:
            begin
                resp_kind_next   = mstp_pkg::KIND_ERR;
                resp_handle_next = '0;
                scan_idx_next    = '0;
                found_next       = 1'b0;
                case (req_type_reg)
                    mstp_pkg::REQ_CREATE:
                    begin
                    end
                    mstp_pkg::REQ_START, mstp_pkg::REQ_RESET:
                    begin
                        // Fetch the period; the deadline is written in the next cycle
                        ctl.rd_en = slot_ok && cur_active;
                    end
                    mstp_pkg::REQ_STOP:
                    begin
                        if (slot_ok)
                        begin
                            ctl.clr_armed  = 1'b1;
                            resp_kind_next = mstp_pkg::KIND_OK;
                        end
                    end
                    mstp_pkg::REQ_DELETE:
                    begin
                        if (slot_ok)
                        begin
                            ctl.clr_active = 1'b1;
                            ctl.clr_armed  = 1'b1;
                            resp_kind_next = mstp_pkg::KIND_OK;
                        end
                    end
                    mstp_pkg::REQ_POLL:
                    begin
                        resp_kind_next = mstp_pkg::KIND_NONE;
                    end
                    default:
                    begin
                    end
                endcase
            end
            mstp_pkg::ST_SCAN:
            begin
                // Take the first free slot, else advance
                if (!cur_active)
                begin
                    ctl.set_active   = 1'b1;
                    ctl.clr_armed    = 1'b1;
                    ctl.pr_we        = 1'b1;
                    resp_kind_next   = mstp_pkg::KIND_OK;
                    resp_handle_next = idx_handle;
                end
                else if (!scan_end)
                begin
                    scan_idx_next = idx_inc;
                end
            end
            mstp_pkg::ST_ARM:
            begin
                ctl.dl_we      = 1'b1;
                ctl.set_armed  = 1'b1;
                resp_kind_next = mstp_pkg::KIND_OK;
            end
            mstp_pkg::ST_POLL_RD:
            begin
                if (cur_active && cur_armed)
                begin
                    ctl.rd_en = 1'b1;
                end
                else if (scan_end)
                begin
                    resp_kind_next = found_reg ? mstp_pkg::KIND_EXP : mstp_pkg::KIND_NONE;
                end
                else
                begin
                    scan_idx_next = idx_inc;
                end
            end
            mstp_pkg::ST_POLL_EVAL:
            begin
                if (eval_go)
                begin
                    if (expired)
                    begin
                        // Re-arm a periodic slot, disarm a one-shot slot
                        if (rd_periodic)
                        begin
                            ctl.dl_we = 1'b1;
                        end
                        else
                        begin
                            ctl.clr_armed = 1'b1;
                        end
                        // Release the previously held expiry; it is not the final one
                        if (found_reg)
                        begin
                            push            = 1'b1;
                            out_kind_next   = mstp_pkg::KIND_EXP;
                            out_handle_next = resp_handle_reg;
                            out_last_next   = 1'b0;
                        end
                        resp_handle_next = idx_handle;
                        found_next       = 1'b1;
                    end
                    if (scan_end)
                    begin
                        resp_kind_next = (expired || found_reg) ? mstp_pkg::KIND_EXP
                                                                : mstp_pkg::KIND_NONE;
                    end
                    else
                    begin
                        scan_idx_next = idx_inc;
                    end
                end
            end
            mstp_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    push            = 1'b1;
                    out_kind_next   = resp_kind_reg;
                    out_handle_next = resp_handle_reg;
                    out_last_next   = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid_next = push ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mstp_pkg::ST_IDLE;
            pool_en_reg   <= 1'b0;
            scan_idx_reg  <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                pool_en_reg <= cfg_wdata;
            end
        end
    end

    // Request capture and result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == mstp_pkg::ST_IDLE && in_valid)
        begin
            req_type_reg   <= mstp_pkg::req_type_t'(in_type);
            req_handle_reg <= in_handle;
            req_period_reg <= in_period;
            req_reload_reg <= in_reload;
            req_now_reg    <= in_now;
        end
        resp_kind_reg   <= resp_kind_next;
        resp_handle_reg <= resp_handle_next;
        out_kind_reg    <= out_kind_next;
        out_handle_reg  <= out_handle_next;
        out_last_reg    <= out_last_next;
    end

    assign in_ready    = (state_reg == mstp_pkg::ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign out_kind    = out_kind_reg;
    assign out_handle  = out_handle_reg;
    assign out_last    = out_last_reg;
    assign wr_deadline = sat_deadline;
    assign wr_period   = req_period_reg;
    assign wr_periodic = req_reload_reg;

endmodule

@@ hw/rtl/multi_slot_timer_pool.sv @@
// Stop, delete and rejected requests go from decode straight to the result state;
// start and reset pass through the arm state, create walks the slots up to the lowest free
// one or through all of them, and an enabled poll reads each slot and evaluates each active
// armed one; an output stall holds the result state and the poll walk. One request at a time.
// The result register lets the next request in early.
// Reset: flags, sequencer and pool_enabled clear at once; memories need no clearing pass.
module multi_slot_timer_pool #(
    parameter int SLOTS     = mstp_pkg::SLOTS_DEF,
    parameter int TIME_BITS = mstp_pkg::TIME_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic                             cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // handle[3:0], period[35:4], reload_mode[36], now_ms[84:37], zero fill
    input  logic [mstp_pkg::S_TDATA_W-1:0]   s_tdata,
    // req_type[2:0]
    input  logic [mstp_pkg::TYPE_W-1:0]      s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // result_handle[3:0], zero fill
    output logic [mstp_pkg::M_TDATA_W-1:0]   m_tdata,
    // result_kind[1:0]
    output logic [mstp_pkg::KIND_W-1:0]      m_tuser,
    output logic                             m_tlast
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    mstp_pkg::slot_ctl_t            ctl;
    logic [IDX_W-1:0]               slot_addr;
    logic [TIME_BITS-1:0]           wr_deadline;
    logic [mstp_pkg::PERIOD_W-1:0]  wr_period;
    logic                           wr_periodic;
    logic [TIME_BITS-1:0]           rd_deadline;
    logic [mstp_pkg::PERIOD_W-1:0]  rd_period;
    logic                           rd_periodic;
    logic [SLOTS-1:0]               active;
    logic [SLOTS-1:0]               armed;
    logic [mstp_pkg::NOW_W-1:0]     in_now_raw;
    logic [TIME_BITS-1:0]           in_now;
    logic [mstp_pkg::HANDLE_W-1:0]  out_handle;

    // Take the time modulo the configured time width
    assign in_now_raw = s_tdata[84:37];
    assign in_now     = TIME_BITS'(64'(in_now_raw));

    mstp_seq #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_type     (s_tuser),
        .in_handle   (s_tdata[3:0]),
        .in_period   (s_tdata[35:4]),
        .in_reload   (s_tdata[36]),
        .in_now      (in_now),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_kind    (m_tuser),
        .out_handle  (out_handle),
        .out_last    (m_tlast),
        .ctl         (ctl),
        .slot_addr   (slot_addr),
        .wr_deadline (wr_deadline),
        .wr_period   (wr_period),
        .wr_periodic (wr_periodic),
        .rd_deadline (rd_deadline),
        .rd_period   (rd_period),
        .rd_periodic (rd_periodic),
        .active      (active),
        .armed       (armed)
    );

    mstp_slot_store #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .addr        (slot_addr),
        .wr_deadline (wr_deadline),
        .wr_period   (wr_period),
        .wr_periodic (wr_periodic),
        .rd_deadline (rd_deadline),
        .rd_period   (rd_period),
        .rd_periodic (rd_periodic),
        .active      (active),
        .armed       (armed)
    );

    // Pack the result handle into the output data bytes
    assign m_tdata = {{(mstp_pkg::M_TDATA_W - mstp_pkg::HANDLE_W){1'b0}}, out_handle};

endmodule

@@ sim/multi_slot_timer_pool_tb.sv @@
// Self-checking testbench of the timer slot pool: directed table, random requests, scoreboard.
`timescale 1ns / 100ps

module multi_slot_timer_pool_tb;
    import mstp_pkg::*;

    localparam int SLOTS = 8;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 100;
    localparam int IDLE_PCT = 27;
    localparam logic [2:0] REQ_BAD6 = 3'd6;
    localparam logic [2:0] REQ_BAD7 = 3'd7;
    localparam logic [47:0] NOW_MAX = '1;
    localparam logic [31:0] PERIOD_MAX = '1;
    localparam int DIR_N = 26;
    localparam int DIR_ENABLE_AT = 6;

    typedef struct {
        logic [2:0]  code;
        logic [3:0]  hnd;
        logic [31:0] period;
        logic        reload;
        logic [47:0] now;
    } req_t;

    typedef struct {
        kind_t      kind;
        logic [3:0] hnd;
        logic       lst;
    } outcome_t;

    // One directed row: the request, plus a typed-in result where it is obvious
    typedef struct {
        logic [2:0]  code;
        logic [3:0]  hnd;
        logic [31:0] period;
        logic        reload;
        logic [47:0] now;
        bit          known;
        kind_t       kind;
        logic [3:0]  rh;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic                   cfg_wdata = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [TYPE_W-1:0]      s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [KIND_W-1:0]      m_tuser;
    logic                   m_tlast;

    // Predictor copy of the pool
    bit          pool_on;
    bit          slot_used [SLOTS];
    bit          slot_auto [SLOTS];
    logic [31:0] slot_ms   [SLOTS];
    logic [47:0] slot_due  [SLOTS];

    outcome_t    step_results [$];
    outcome_t    pending_results [$];

    int          n_sent;
    int          n_checked;
    int          n_expiries;
    int          n_fail;
    int          hold_left;
    bit          hold_done;
    bit          send_calm;
    logic [47:0] tbase;

    stim_row_t dir_rows [DIR_N] = '{
        // pool disabled
        '{REQ_CREATE, 4'd0, 32'd5,      1'b1, 48'd0,   1'b1, KIND_ERR,  4'd0},
        '{REQ_POLL,   4'd0, 32'd0,      1'b0, NOW_MAX, 1'b1, KIND_NONE, 4'd0},
        '{REQ_START,  4'd1, 32'd0,      1'b0, 48'd10,  1'b1, KIND_ERR,  4'd0},
        '{REQ_STOP,   4'd1, 32'd0,      1'b0, 48'd0,   1'b1, KIND_OK,   4'd0},
        '{REQ_DELETE, 4'd8, 32'd0,      1'b0, 48'd0,   1'b1, KIND_OK,   4'd0},
        '{REQ_BAD6,   4'd1, PERIOD_MAX, 1'b1, NOW_MAX, 1'b1, KIND_ERR,  4'd0},
        // pool enabled: fill every slot, then overflow it
        '{REQ_CREATE, 4'd0, 32'd0,      1'b0, 48'd0,   1'b1, KIND_ERR,  4'd0},
        '{REQ_CREATE, 4'd0, 32'd5,      1'b0, 48'd0,   1'b1, KIND_OK,   4'd1},
        '{REQ_CREATE, 4'd0, PERIOD_MAX, 1'b1, 48'd0,   1'b1, KIND_OK,   4'd2},
        '{REQ_CREATE, 4'd0, 32'd1,      1'b1, 48'd0,   1'b1, KIND_OK,   4'd3},
        '{REQ_CREATE, 4'd0, 32'd20,     1'b0, 48'd0,   1'b0, KIND_OK,   4'd0},
        '{REQ_CREATE, 4'd0, 32'd7,      1'b1, 48'd0,   1'b0, KIND_OK,   4'd0},
        '{REQ_CREATE, 4'd0, 32'd3,      1'b0, 48'd0,   1'b0, KIND_OK,   4'd0},
        '{REQ_CREATE, 4'd0, 32'd2,      1'b1, 48'd0,   1'b0, KIND_OK,   4'd0},
        '{REQ_CREATE, 4'd0, 32'd9,      1'b0, 48'd0,   1'b0, KIND_OK,   4'd0},
        '{REQ_CREATE, 4'd0, 32'd4,      1'b0, 48'd0,   1'b1, KIND_ERR,  4'd0},
        // bad handles
        '{REQ_START,  4'd0, 32'd0,      1'b0, 48'd5,   1'b1, KIND_ERR,  4'd0},
        '{REQ_RESET,  4'd9, 32'd0,      1'b0, 48'd5,   1'b1, KIND_ERR,  4'd0},
        '{REQ_STOP,   4'd15, 32'd0,     1'b0, 48'd5,   1'b1, KIND_ERR,  4'd0},
        // arm, saturate, expire
        '{REQ_START,  4'd1, 32'd0,      1'b0, 48'd100, 1'b0, KIND_OK,   4'd0},
        '{REQ_START,  4'd2, 32'd0,      1'b0, NOW_MAX, 1'b0, KIND_OK,   4'd0},
        '{REQ_RESET,  4'd3, 32'd0,      1'b0, 48'd0,   1'b0, KIND_OK,   4'd0},
        '{REQ_POLL,   4'd0, 32'd0,      1'b0, 48'd110, 1'b0, KIND_OK,   4'd0},
        '{REQ_POLL,   4'd0, 32'd0,      1'b0, NOW_MAX, 1'b0, KIND_OK,   4'd0},
        '{REQ_BAD7,   4'd0, 32'd0,      1'b0, 48'd0,   1'b1, KIND_ERR,  4'd0},
        '{REQ_DELETE, 4'd1, 32'd0,      1'b0, 48'd0,   1'b1, KIND_OK,   4'd0}
    };

    multi_slot_timer_pool dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Saturate now + period at the top of the time range
    function automatic logic [47:0] saturated_due(logic [47:0] now, logic [31:0] per);
        logic [48:0] sum;
        sum = {1'b0, now} + {17'd0, per};
        return sum[48] ? NOW_MAX : sum[47:0];
    endfunction

    // Map a one-based handle to a slot index, -1 when out of range
    function automatic int slot_index(logic [3:0] h);
        return (h == 4'd0 || h > SLOTS) ? -1 : int'(h) - 1;
    endfunction

    function automatic outcome_t outcome(kind_t k, logic [3:0] h, logic l);
        outcome_t o;
        o.kind = k;
        o.hnd = h;
        o.lst = l;
        return o;
    endfunction

    // Compute the results of one request and advance the slot state
    function automatic void predict_pool_response(req_t r);
        int s;
        int i;
        step_results.delete();
        case (r.code)
            REQ_CREATE:
            begin
                s = -1;
                if (pool_on && r.period != 32'd0)
                begin
                    for (i = SLOTS - 1; i >= 0; i--)
                        if (!slot_used[i])
                            s = i;
                end
                if (s < 0)
                    step_results.push_back(outcome(KIND_ERR, 4'd0, 1'b1));
                else
                begin
                    slot_used[s] = 1'b1;
                    slot_auto[s] = r.reload;
                    slot_ms[s] = r.period;
                    slot_due[s] = '0;
                    step_results.push_back(outcome(KIND_OK, 4'(s + 1), 1'b1));
                end
            end
            REQ_START, REQ_RESET:
            begin
                s = slot_index(r.hnd);
                if (s < 0 || !slot_used[s])
                    step_results.push_back(outcome(KIND_ERR, 4'd0, 1'b1));
                else
                begin
                    slot_due[s] = saturated_due(r.now, slot_ms[s]);
                    step_results.push_back(outcome(KIND_OK, 4'd0, 1'b1));
                end
            end
            REQ_STOP, REQ_DELETE:
            begin
                s = slot_index(r.hnd);
                if (s < 0)
                    step_results.push_back(outcome(KIND_ERR, 4'd0, 1'b1));
                else
                begin
                    slot_due[s] = '0;
                    if (r.code == REQ_DELETE)
                    begin
                        slot_used[s] = 1'b0;
                        slot_auto[s] = 1'b0;
                        slot_ms[s] = '0;
                    end
                    step_results.push_back(outcome(KIND_OK, 4'd0, 1'b1));
                end
            end
            REQ_POLL:
            begin
                if (pool_on)
                begin
                    for (i = 0; i < SLOTS; i++)
                    begin
                        if (slot_used[i] && slot_due[i] != '0 && r.now >= slot_due[i])
                        begin
                            slot_due[i] = slot_auto[i] ? saturated_due(r.now, slot_ms[i]) : '0;
                            step_results.push_back(outcome(KIND_EXP, 4'(i + 1), 1'b0));
                        end
                    end
                end
                if (step_results.size() == 0)
                    step_results.push_back(outcome(KIND_NONE, 4'd0, 1'b1));
                else
                    step_results[step_results.size() - 1].lst = 1'b1;
            end
            default:
                step_results.push_back(outcome(KIND_ERR, 4'd0, 1'b1));
        endcase
    endfunction

    // Offer one request, wait for its transaction, queue what it should produce
    task automatic send_req(req_t r, bit known, kind_t k, logic [3:0] h);
        while (!send_calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, r.now, r.reload, r.period, r.hnd};
        s_tuser <= r.code;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_pool_response(r);
        if (known)
            pending_results.push_back(outcome(k, h, 1'b1));
        else
            foreach (step_results[i])
                pending_results.push_back(step_results[i]);
        n_sent++;
    endtask

    // Build a random request around a slowly advancing clock
    task automatic make_random_req(output req_t r);
        int pick;
        int psel;
        pick = $urandom_range(0, 99);
        psel = $urandom_range(0, 9);
        r.code = REQ_POLL;
        r.hnd = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
        r.period = $urandom;
        r.reload = 1'($urandom_range(0, 1));
        r.now = {16'($urandom), 32'($urandom)};
        tbase = tbase + 48'($urandom_range(0, 15));
        if (pick < 16)
        begin
            r.code = REQ_CREATE;
            if (psel == 0)
                r.period = '0;
            else if (psel > 2)
                r.period = 32'($urandom_range(1, 40));
        end
        else if (pick < 42)
        begin
            r.code = (pick < 36) ? REQ_START : REQ_RESET;
            r.now = tbase;
        end
        else if (pick < 56)
            r.code = (pick < 50) ? REQ_STOP : REQ_DELETE;
        else if (pick < 90)
        begin
            r.code = REQ_POLL;
            r.now = ($urandom_range(0, 39) == 0) ? NOW_MAX : tbase;
        end
        else if (pick < 94)
            r.code = 3'($urandom_range(REQ_BAD6, REQ_BAD7));
        else
            r.code = 3'($urandom_range(0, 7));
    endtask

    // Stop offering and let every queued result come back
    task automatic wait_pool_quiet();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_pool_enable(bit v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        pool_on = v;
    endtask

    task automatic run_random(int count, int calm_lo, int calm_hi);
        req_t r;
        for (int i = 0; i < count; i++)
        begin
            send_calm = (i >= calm_lo && i < calm_hi);
            make_random_req(r);
            send_req(r, 1'b0, KIND_OK, 4'd0);
        end
        send_calm = 1'b0;
    endtask

    // Check each result transaction and drive the receiver side
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result kind %0d handle %0d last %0b",
                         $time, m_tuser, m_tdata[3:0], m_tlast);
                n_fail++;
            end
            else
            begin
                if (m_tuser !== pending_results[0].kind)
                begin
                    $display("%0t: kind expected %0d actual %0d", $time,
                             pending_results[0].kind, m_tuser);
                    n_fail++;
                end
                if (m_tdata !== {4'd0, pending_results[0].hnd})
                begin
                    $display("%0t: handle expected %0d actual %0d", $time,
                             pending_results[0].hnd, m_tdata);
                    n_fail++;
                end
                if (m_tlast !== pending_results[0].lst)
                begin
                    $display("%0t: last expected %0b actual %0b", $time,
                             pending_results[0].lst, m_tlast);
                    n_fail++;
                end
                if (pending_results[0].kind == KIND_EXP)
                    n_expiries++;
                void'(pending_results.pop_front());
            end
            n_checked++;
        end

        // Hold off once for a long stretch, keep a calm window, otherwise stall at random
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (!hold_done && n_checked >= 30)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (n_checked >= 70 && n_checked < 110)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Watchdog: end the run if nothing moves for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("multi_slot_timer_pool_tb: FAIL");
        $finish;
    end

    initial
    begin
        req_t r;
        pool_on = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_used[i] = 1'b0;
            slot_auto[i] = 1'b0;
            slot_ms[i] = '0;
            slot_due[i] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: disabled pool first, then enable and walk the rest
        for (int i = 0; i < DIR_N; i++)
        begin
            if (i == DIR_ENABLE_AT)
            begin
                wait_pool_quiet();
                write_pool_enable(1'b1);
            end
            r.code = dir_rows[i].code;
            r.hnd = dir_rows[i].hnd;
            r.period = dir_rows[i].period;
            r.reload = dir_rows[i].reload;
            r.now = dir_rows[i].now;
            send_req(r, dir_rows[i].known, dir_rows[i].kind, dir_rows[i].rh);
        end

        // Random traffic: enabled, disabled, enabled again
        tbase = 48'd200;
        run_random(40, 8, 32);
        wait_pool_quiet();
        write_pool_enable(1'b0);
        run_random(12, 0, 0);
        wait_pool_quiet();
        write_pool_enable(1'b1);
        run_random(32, 0, 0);

        wait_pool_quiet();
        repeat (20) @(posedge clk);

        $display("Covered %0d requests over three enable phases, %0d results checked,",
                 n_sent, n_checked);
        $display("%0d slot expiries, %0d mismatches", n_expiries, n_fail);
        if (n_fail == 0)
            $display("multi_slot_timer_pool_tb: PASS");
        else
            $display("multi_slot_timer_pool_tb: FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/mstp_pkg.sv
hw/rtl/mstp_slot_store.sv
hw/rtl/mstp_seq.sv
hw/rtl/multi_slot_timer_pool.sv
sim/multi_slot_timer_pool_tb.sv
